// File: rtl/qr_module_classify_and_mask_assert.svh
// Assertion macros for the QR module classifier.
// Each macro takes a label, the clock, the active-low reset, a condition
// that starts the check and the condition that must then hold.
`ifndef QR_MODULE_CLASSIFY_AND_MASK_ASSERT_SVH
`define QR_MODULE_CLASSIFY_AND_MASK_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define QRCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrcm: same-cycle check failed");
// Next-cycle implication
`define QRCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrcm: next-cycle check failed");
`else
`define QRCM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QRCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/qrcm_pkg.sv
`default_nettype none

package qrcm_pkg;

    // Input word: one module position and its unmasked data bit
    typedef struct packed {
        logic [7:0] column;
        logic [7:0] row;
        logic       data_bit;
    } t_in_word;

    // Result word: final module value and its classification
    typedef struct packed {
        logic module_value;
        logic function_module;
        logic hard_border;
        logic soft_border;
        logic out_of_range;
    } t_out_word;

    // Classification handed from the pattern decoder to the masking stage
    typedef struct packed {
        logic out_of_range;
        logic function_module;
        logic hard_border;
        logic soft_border;
        logic fixed_value;
    } t_class;

    // Configuration register indexes
    localparam logic [1:0] REG_VERSION = 2'd0;
    localparam logic [1:0] REG_ECC     = 2'd1;
    localparam logic [1:0] REG_MASK    = 2'd2;

    // Data mask patterns
    typedef enum logic [2:0] {
        MASK_CHECKER, MASK_ROWS, MASK_COLS3, MASK_DIAG3,
        MASK_BLOCKS, MASK_PROD_SUM, MASK_PROD_PAR, MASK_PROD_MIXED
    } t_mask;

    // Version information words, versions 7 through 40
    localparam logic [17:0] VER_WORDS [34] = '{
        18'h07c94, 18'h085bc, 18'h09a99, 18'h0a4d3, 18'h0bbf6, 18'h0c762, 18'h0d847,
        18'h0e60d, 18'h0f928, 18'h10b78, 18'h1145d, 18'h12a17, 18'h13532, 18'h149a6,
        18'h15683, 18'h168c9, 18'h177ec, 18'h18ec4, 18'h191e1, 18'h1afab, 18'h1b08e,
        18'h1cc1a, 18'h1d33f, 18'h1ed75, 18'h1f250, 18'h209d5, 18'h216f0, 18'h228ba,
        18'h2379f, 18'h24b0b, 18'h2542e, 18'h26a64, 18'h27541, 18'h28c69
    };

    // Format words by error correction row and mask pattern
    localparam logic [14:0] FMT_WORDS [4][8] = '{
        '{15'h5412, 15'h5125, 15'h5e7c, 15'h5b4b, 15'h45f9, 15'h40ce, 15'h4f97, 15'h4aa0},
        '{15'h77c4, 15'h72f3, 15'h7daa, 15'h789d, 15'h662f, 15'h6318, 15'h6c41, 15'h6976},
        '{15'h1689, 15'h13be, 15'h1ce7, 15'h19d0, 15'h0762, 15'h0255, 15'h0d0c, 15'h083b},
        '{15'h355f, 15'h3068, 15'h3f31, 15'h3a06, 15'h24b4, 15'h2183, 15'h2eda, 15'h2bed}
    };

    // Finder rows including the separator row
    localparam logic [7:0] FINDER_ROWS [8] = '{
        8'h7f, 8'h41, 8'h5d, 8'h5d, 8'h5d, 8'h41, 8'h7f, 8'h00
    };

    localparam logic [4:0] ALIGN_ROWS [5] = '{5'h1f, 5'h11, 5'h15, 5'h11, 5'h1f};

    localparam int unsigned ALIGN_SLOTS = 7;

    // Alignment centers per version index; zero marks an unused slot
    localparam logic [7:0] ALIGN_POS [40][ALIGN_SLOTS] = '{
        '{default:8'd0},
        '{0:8'd6, 1:8'd18, default:8'd0},
        '{0:8'd6, 1:8'd22, default:8'd0},
        '{0:8'd6, 1:8'd26, default:8'd0},
        '{0:8'd6, 1:8'd30, default:8'd0},
        '{0:8'd6, 1:8'd34, default:8'd0},
        '{0:8'd6, 1:8'd22, 2:8'd38, default:8'd0},
        '{0:8'd6, 1:8'd24, 2:8'd42, default:8'd0},
        '{0:8'd6, 1:8'd26, 2:8'd46, default:8'd0},
        '{0:8'd6, 1:8'd28, 2:8'd50, default:8'd0},
        '{0:8'd6, 1:8'd30, 2:8'd54, default:8'd0},
        '{0:8'd6, 1:8'd32, 2:8'd58, default:8'd0},
        '{0:8'd6, 1:8'd34, 2:8'd62, default:8'd0},
        '{0:8'd6, 1:8'd26, 2:8'd46, 3:8'd66, default:8'd0},
        '{0:8'd6, 1:8'd26, 2:8'd48, 3:8'd70, default:8'd0},
        '{0:8'd6, 1:8'd26, 2:8'd50, 3:8'd74, default:8'd0},
        '{0:8'd6, 1:8'd30, 2:8'd54, 3:8'd78, default:8'd0},
        '{0:8'd6, 1:8'd30, 2:8'd56, 3:8'd82, default:8'd0},
        '{0:8'd6, 1:8'd30, 2:8'd58, 3:8'd86, default:8'd0},
        '{0:8'd6, 1:8'd34, 2:8'd62, 3:8'd90, default:8'd0},
        '{0:8'd6, 1:8'd28, 2:8'd50, 3:8'd72, 4:8'd94, default:8'd0},
        '{0:8'd6, 1:8'd26, 2:8'd50, 3:8'd74, 4:8'd98, default:8'd0},
        '{0:8'd6, 1:8'd30, 2:8'd54, 3:8'd78, 4:8'd102, default:8'd0},
        '{0:8'd6, 1:8'd28, 2:8'd54, 3:8'd80, 4:8'd106, default:8'd0},
        '{0:8'd6, 1:8'd32, 2:8'd58, 3:8'd84, 4:8'd110, default:8'd0},
        '{0:8'd6, 1:8'd30, 2:8'd58, 3:8'd86, 4:8'd114, default:8'd0},
        '{0:8'd6, 1:8'd34, 2:8'd62, 3:8'd90, 4:8'd118, default:8'd0},
        '{0:8'd6, 1:8'd26, 2:8'd50, 3:8'd74, 4:8'd98, 5:8'd122, default:8'd0},
        '{0:8'd6, 1:8'd30, 2:8'd54, 3:8'd78, 4:8'd102, 5:8'd126, default:8'd0},
        '{0:8'd6, 1:8'd26, 2:8'd52, 3:8'd78, 4:8'd104, 5:8'd130, default:8'd0},
        '{0:8'd6, 1:8'd30, 2:8'd56, 3:8'd82, 4:8'd108, 5:8'd134, default:8'd0},
        '{0:8'd6, 1:8'd34, 2:8'd60, 3:8'd86, 4:8'd112, 5:8'd138, default:8'd0},
        '{0:8'd6, 1:8'd30, 2:8'd58, 3:8'd86, 4:8'd114, 5:8'd142, default:8'd0},
        '{0:8'd6, 1:8'd34, 2:8'd62, 3:8'd90, 4:8'd118, 5:8'd146, default:8'd0},
        '{0:8'd6, 1:8'd30, 2:8'd54, 3:8'd78, 4:8'd102, 5:8'd126, 6:8'd150},
        '{0:8'd6, 1:8'd24, 2:8'd50, 3:8'd76, 4:8'd102, 5:8'd128, 6:8'd154},
        '{0:8'd6, 1:8'd28, 2:8'd54, 3:8'd80, 4:8'd106, 5:8'd132, 6:8'd158},
        '{0:8'd6, 1:8'd32, 2:8'd58, 3:8'd84, 4:8'd110, 5:8'd136, 6:8'd162},
        '{0:8'd6, 1:8'd26, 2:8'd54, 3:8'd82, 4:8'd110, 5:8'd138, 6:8'd166},
        '{0:8'd6, 1:8'd30, 2:8'd58, 3:8'd86, 4:8'd114, 5:8'd142, 6:8'd170}
    };

endpackage

`default_nettype wire

// File: rtl/qrcm_classify.sv
`default_nettype none

module qrcm_classify (
    input  wire logic [5:0]      i_version,
    input  wire logic [1:0]      i_ecc_level,
    input  wire logic [2:0]      i_mask_select,
    input  wire logic [7:0]      i_column,
    input  wire logic [7:0]      i_row,
    output qrcm_pkg::t_class     o_class
);
    import qrcm_pkg::*;

    function automatic logic in_finder(input logic [7:0] s, input logic [7:0] x,
                                       input logic [7:0] y);
        return (x < 8'd8 && (y < 8'd8 || y >= s - 8'd8)) || (y < 8'd8 && x >= s - 8'd8);
    endfunction

    logic [7:0]  size;
    logic [7:0]  ver_base;
    logic [5:0]  ver_idx;
    logic [17:0] ver_word;
    logic [14:0] fmt_word;
    logic        oor;

    logic        ver_hit;
    logic [4:0]  ver_bit;
    logic        dark_hit;
    logic        fmt_hit;
    logic [3:0]  fmt_bit;
    logic        finder_hit;
    logic [2:0]  finder_x;
    logic [2:0]  finder_y;
    logic        align_x_hit;
    logic        align_y_hit;
    logic [7:0]  align_cx;
    logic [7:0]  align_cy;
    logic        align_hit;
    logic [2:0]  align_dx;
    logic [2:0]  align_dy;
    logic        timing_v;
    logic        timing_h;

    // Symbol size and lookups driven by configuration
    assign size     = 8'({i_version, 2'b00}) + 8'd21;
    assign ver_base = size - 8'd11;
    assign ver_idx  = (i_version >= 6'd6) ? (i_version - 6'd6) : 6'd0;
    assign ver_word = VER_WORDS[ver_idx];
    assign fmt_word = FMT_WORDS[i_ecc_level][i_mask_select];
    assign oor      = (i_column >= size) || (i_row >= size);

    // Version information blocks, bottom-left and top-right
    always_comb begin
        ver_hit = 1'b0;
        ver_bit = '0;
        if (i_version >= 6'd6) begin
            if (i_column >= ver_base && i_column <= ver_base + 8'd2 && i_row < 8'd6) begin
                ver_hit = 1'b1;
                ver_bit = 5'(i_row[2:0]) * 5'd3 + 5'(i_column - ver_base);
            end else if (i_row >= ver_base && i_row <= ver_base + 8'd2
                         && i_column < 8'd6) begin
                ver_hit = 1'b1;
                ver_bit = 5'(i_column[2:0]) * 5'd3 + 5'(i_row - ver_base);
            end
        end
    end

    assign dark_hit = (i_column == 8'd8) && (i_row == size - 8'd8);

    // Format information bit position
    always_comb begin
        fmt_hit = 1'b0;
        fmt_bit = '0;
        priority if (i_row == 8'd8 && i_column >= size - 8'd8) begin
            fmt_hit = 1'b1;
            fmt_bit = 4'(size - 8'd1 - i_column);
        end else if (i_row == 8'd8 && i_column == 8'd8) begin
            fmt_hit = 1'b1;
            fmt_bit = 4'd7;
        end else if (i_row == 8'd8 && i_column == 8'd7) begin
            fmt_hit = 1'b1;
            fmt_bit = 4'd8;
        end else if (i_row == 8'd8 && i_column <= 8'd5) begin
            fmt_hit = 1'b1;
            fmt_bit = 4'(8'd14 - i_column);
        end else if (i_column == 8'd8 && i_row >= size - 8'd7) begin
            fmt_hit = 1'b1;
            fmt_bit = 4'(8'd8 + i_row - (size - 8'd7));
        end else if (i_column == 8'd8 && i_row <= 8'd5) begin
            fmt_hit = 1'b1;
            fmt_bit = 4'(i_row);
        end else if (i_column == 8'd8 && i_row == 8'd7) begin
            fmt_hit = 1'b1;
            fmt_bit = 4'd6;
        end else begin
            fmt_hit = 1'b0;
        end
    end

    // Finder and separator, folded onto the top-left corner
    assign finder_hit = in_finder(size, i_column, i_row);
    assign finder_x   = (i_column < 8'd8) ? i_column[2:0] : 3'(size - 8'd1 - i_column);
    assign finder_y   = (i_row < 8'd8) ? i_row[2:0] : 3'(size - 8'd1 - i_row);

    // Alignment windows: centers lie far apart, so at most one matches per axis
    always_comb begin
        align_x_hit = 1'b0;
        align_y_hit = 1'b0;
        align_cx    = '0;
        align_cy    = '0;
        for (int k = 0; k < ALIGN_SLOTS; k++) begin
            if (ALIGN_POS[i_version][k] != 8'd0
                && {1'b0, i_column} + 9'd2 >= {1'b0, ALIGN_POS[i_version][k]}
                && {1'b0, i_column} <= {1'b0, ALIGN_POS[i_version][k]} + 9'd2) begin
                align_x_hit = 1'b1;
                align_cx    = ALIGN_POS[i_version][k];
            end
            if (ALIGN_POS[i_version][k] != 8'd0
                && {1'b0, i_row} + 9'd2 >= {1'b0, ALIGN_POS[i_version][k]}
                && {1'b0, i_row} <= {1'b0, ALIGN_POS[i_version][k]} + 9'd2) begin
                align_y_hit = 1'b1;
                align_cy    = ALIGN_POS[i_version][k];
            end
        end
    end

    // Drop alignment patterns whose center sits on a finder
    assign align_hit = align_x_hit && align_y_hit && !in_finder(size, align_cx, align_cy);
    assign align_dx  = 3'(i_column - align_cx + 8'd2);
    assign align_dy  = 3'(i_row - align_cy + 8'd2);

    assign timing_v = (i_column == 8'd6) && (i_row >= 8'd8) && (i_row <= size - 8'd9);
    assign timing_h = (i_row == 8'd6) && (i_column >= 8'd8) && (i_column <= size - 8'd9);

    // First pattern in priority order claims the module
    always_comb begin
        o_class = '0;
        priority if (oor) begin
            o_class.out_of_range = 1'b1;
        end else if (ver_hit) begin
            o_class.function_module = 1'b1;
            o_class.hard_border     = 1'b1;
            o_class.fixed_value     = ver_word[ver_bit];
        end else if (dark_hit) begin
            o_class.function_module = 1'b1;
            o_class.hard_border     = 1'b1;
            o_class.fixed_value     = 1'b1;
        end else if (fmt_hit) begin
            o_class.function_module = 1'b1;
            o_class.hard_border     = 1'b1;
            o_class.fixed_value     = fmt_word[fmt_bit];
        end else if (finder_hit) begin
            o_class.function_module = 1'b1;
            o_class.hard_border     = 1'b1;
            o_class.fixed_value     = FINDER_ROWS[finder_y][finder_x];
        end else if (align_hit) begin
            o_class.function_module = 1'b1;
            o_class.soft_border     = 1'b1;
            o_class.fixed_value     = ALIGN_ROWS[align_dy][align_dx];
        end else if (timing_v) begin
            o_class.function_module = 1'b1;
            o_class.soft_border     = 1'b1;
            o_class.fixed_value     = ~i_row[0];
        end else if (timing_h) begin
            o_class.function_module = 1'b1;
            o_class.soft_border     = 1'b1;
            o_class.fixed_value     = ~i_column[0];
        end else begin
            o_class.function_module = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/qrcm_mask.sv
`default_nettype none

module qrcm_mask (
    input  wire logic [2:0]      i_mask_select,
    input  wire qrcm_pkg::t_in_word i_word,
    input  wire qrcm_pkg::t_class   i_class,
    output qrcm_pkg::t_out_word  o_word
);
    import qrcm_pkg::*;

    // Divide an 8-bit value by three through its reciprocal
    function automatic logic [7:0] div3(input logic [7:0] a);
        logic [15:0] prod;
        prod = 16'(a) * 16'd171;
        return 8'(prod[15:9]);
    endfunction

    function automatic logic [1:0] mod3(input logic [7:0] a);
        logic [7:0] q;
        q = div3(a);
        return 2'(a - (q + q + q));
    endfunction

    // Residue of a sum or product of two residues; products give only 0, 1, 2 and 4
    function automatic logic [1:0] mod3_small(input logic [3:0] a);
        return (a >= 4'd3) ? 2'(a - 4'd3) : a[1:0];
    endfunction

    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] x_m3;
    logic [1:0] y_m3;
    logic [7:0] x_d3;
    logic [1:0] sum_m3;
    logic [1:0] prod_m3;
    logic       sum_par;
    logic       prod_par;
    logic       flip;

    assign x        = i_word.column;
    assign y        = i_word.row;
    assign x_m3     = mod3(x);
    assign y_m3     = mod3(y);
    assign x_d3     = div3(x);
    assign sum_m3   = mod3_small(4'(x_m3) + 4'(y_m3));
    assign prod_m3  = mod3_small(4'(x_m3) * 4'(y_m3));
    assign sum_par  = x[0] ^ y[0];
    assign prod_par = x[0] & y[0];

    // Select the mask condition
    always_comb begin
        unique case (t_mask'(i_mask_select))
            MASK_CHECKER:    flip = ~sum_par;
            MASK_ROWS:       flip = ~y[0];
            MASK_COLS3:      flip = (x_m3 == 2'd0);
            MASK_DIAG3:      flip = (sum_m3 == 2'd0);
            MASK_BLOCKS:     flip = ~(y[1] ^ x_d3[0]);
            MASK_PROD_SUM:   flip = ~prod_par && (prod_m3 == 2'd0);
            MASK_PROD_PAR:   flip = ~(prod_par ^ prod_m3[0]);
            MASK_PROD_MIXED: flip = ~(prod_m3[0] ^ sum_par);
            default:         flip = 1'b0;
        endcase
    end

    // Merge fixed pattern value with the masked data bit; out-of-range modules read 0
    always_comb begin
        o_word.function_module = i_class.function_module;
        o_word.hard_border     = i_class.hard_border;
        o_word.soft_border     = i_class.soft_border;
        o_word.out_of_range    = i_class.out_of_range;
        priority if (i_class.out_of_range) begin
            o_word.module_value = 1'b0;
        end else if (i_class.function_module) begin
            o_word.module_value = i_class.fixed_value;
        end else begin
            o_word.module_value = i_word.data_bit ^ flip;
        end
    end

endmodule

`default_nettype wire

// File: rtl/qr_module_classify_and_mask.sv
// A word accepted into the input register reaches the output from the result register.
// Throughput: one word per cycle while the output is not stalled; an input register
// and a result register bracket the single pass of pattern decode and masking. The
// input stalls only while both registers hold words and the output is stalled.
// Reset (i_rst_n low at a clock edge) empties both registers and clears version,
// ECC level and mask select to zero.
`default_nettype none
`include "qr_module_classify_and_mask_assert.svh"

module qr_module_classify_and_mask #(
    parameter int MAX_VERSION = 40
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire qrcm_pkg::t_in_word   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output qrcm_pkg::t_out_word       o_out_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import qrcm_pkg::*;

    // Tables stop at version 40, so the limit never goes past it
    localparam logic [5:0] VERSION_LIMIT = 6'((MAX_VERSION > 40) ? 39 : MAX_VERSION - 1);

    logic [5:0] r_version;
    logic [1:0] r_ecc;
    logic [2:0] r_mask;
    logic       r_in_valid;
    t_in_word   r_in;
    logic       r_out_valid;
    t_out_word  r_out;
    t_out_word  n_out;
    t_class     cls;
    logic [5:0] version_sat;
    logic       cfg_write;
    logic       adv_out;
    logic       oor_clean;
    logic       border_split_ok;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= '0;
            r_ecc     <= '0;
            r_mask    <= '0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_VERSION: r_version <= pwdata[5:0];
                REG_ECC:     r_ecc     <= pwdata[1:0];
                REG_MASK:    r_mask    <= pwdata[2:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_VERSION: prdata = 32'(r_version);
            REG_ECC:     prdata = 32'(r_ecc);
            REG_MASK:    prdata = 32'(r_mask);
            default:     prdata = '0;
        endcase
    end

    // Saturate version index to the supported range
    assign version_sat = (r_version > VERSION_LIMIT) ? VERSION_LIMIT : r_version;

    // Pipeline flow control
    assign adv_out     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || adv_out;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Capture input word and result word
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (adv_out && r_in_valid) begin
            r_out <= n_out;
        end
    end

    qrcm_classify u_classify (
        .i_version     (version_sat),
        .i_ecc_level   (r_ecc),
        .i_mask_select (r_mask),
        .i_column      (r_in.column),
        .i_row         (r_in.row),
        .o_class       (cls)
    );

    qrcm_mask u_mask (
        .i_mask_select (r_mask),
        .i_word        (r_in),
        .i_class       (cls),
        .o_word        (n_out)
    );

    // Result word consistency terms
    assign oor_clean = !o_out_data.out_of_range
                       || (!o_out_data.module_value && !o_out_data.function_module
                           && !o_out_data.hard_border && !o_out_data.soft_border);
    assign border_split_ok = !(o_out_data.hard_border && o_out_data.soft_border)
                             && ((o_out_data.hard_border || o_out_data.soft_border)
                                 == o_out_data.function_module);

    // Out-of-range results carry no pattern flags and a light module
    `QRCM_ASSERT_IMP(a_oor_clean, i_clk, i_rst_n, o_out_valid, oor_clean)
    // Hard and soft are exclusive and together make up the function flag
    `QRCM_ASSERT_IMP(a_border_split, i_clk, i_rst_n, o_out_valid, border_split_ok)
    // A held word moves into an empty result register
    `QRCM_ASSERT_NEXT(a_advance, i_clk, i_rst_n, r_in_valid && !r_out_valid, o_out_valid)

endmodule

`default_nettype wire
